// ===== hdl/rrds_pkg.sv =====
// Shared types, codes and constants of the daily rainfall-runoff step.
package rrds_pkg;

    typedef struct packed {
        logic [23:0] rainfall;
        logic [23:0] pet;
    } in_t;

    typedef struct packed {
        logic [23:0] runoff;
        logic [23:0] soil_et;
        logic [23:0] soil_level;
        logic [31:0] ground_level;
    } out_t;

    localparam logic [2:0] REG_INTERCEPT_CAPACITY = 3'd0;
    localparam logic [2:0] REG_INFILTRATION_COEFF = 3'd1;
    localparam logic [2:0] REG_INFILTRATION_SHAPE = 3'd2;
    localparam logic [2:0] REG_SOIL_CAPACITY      = 3'd3;
    localparam logic [2:0] REG_INTERFLOW_COEFF    = 3'd4;
    localparam logic [2:0] REG_RECHARGE_COEFF     = 3'd5;
    localparam logic [2:0] REG_BASEFLOW_COEFF     = 3'd6;

    localparam logic [23:0] INTERCEPT_CAPACITY_RESET = 24'd6144;
    localparam logic [23:0] INFILTRATION_COEFF_RESET = 24'd819200;
    localparam logic [15:0] INFILTRATION_SHAPE_RESET = 16'd8192;
    localparam logic [23:0] SOIL_CAPACITY_RESET      = 24'd1228800;
    localparam logic [16:0] INTERFLOW_COEFF_RESET    = 17'd32768;
    localparam logic [16:0] RECHARGE_COEFF_RESET     = 17'd6554;
    localparam logic [16:0] BASEFLOW_COEFF_RESET     = 17'd19661;
    localparam logic [23:0] SOIL_STORE_RESET         = 24'd614400;

    localparam logic [16:0] FRAC_ONE     = 17'd65536;
    localparam logic [15:0] ET_SCALE     = 16'd40960;
    localparam logic [31:0] ONE30        = 32'h4000_0000;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd13;
    localparam logic [4:0]  WDIV_LAST    = 5'd16;
    localparam logic [4:0]  KDIV_LAST    = 5'd3;
    localparam logic [4:0]  WHOLE_MAX    = 5'd16;
    localparam logic [23:0] MAX24        = 24'hFFFFFF;
    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE, ST_WDIV, ST_MUL_X, ST_SET_E1, ST_MUL_T, ST_DIV_LOAD, ST_DIV_STEP,
        ST_ACC, ST_SET_F, ST_MUL_E, ST_TAKE_E, ST_MUL_INF, ST_INF, ST_MUL_IFW,
        ST_MUL_SRUN, ST_SRUN, ST_MUL_RCW, ST_MUL_REC, ST_REC, ST_MUL_BAS, ST_SOIL,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_WDIV, OP_MUL_X, OP_SET_E1, OP_MUL_T, OP_DIV_LOAD,
        OP_DIV_STEP, OP_ACC, OP_SET_F, OP_MUL_E, OP_TAKE_E, OP_MUL_INF, OP_INF,
        OP_MUL_IFW, OP_MUL_SRUN, OP_SRUN, OP_MUL_RCW, OP_MUL_REC, OP_REC,
        OP_MUL_BAS, OP_SOIL, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] k;
        logic       first;
    } cmd_t;

    typedef struct packed {
        logic [4:0] whole;
        logic       out_busy;
    } status_t;

endpackage

// ===== hdl/rrds_ctrl.sv =====
// Sequencer that steps the datapath through one day's computation.
module rrds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rrds_pkg::status_t status,
    output rrds_pkg::cmd_t    cmd
);

    rrds_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] k_reg, k_next;
    logic       pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrds_pkg::ST_IDLE;
            cnt_reg   <= '0;
            k_reg     <= 4'd1;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        pass_next  = pass_reg;
        case (state_reg)
            rrds_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rrds_pkg::ST_WDIV;
                    cnt_next   = '0;
                end
            end
            rrds_pkg::ST_WDIV:
            begin
                if (cnt_reg == rrds_pkg::WDIV_LAST)
                    state_next = rrds_pkg::ST_MUL_X;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            rrds_pkg::ST_MUL_X:
            begin
                state_next = rrds_pkg::ST_SET_E1;
                k_next     = 4'd1;
                pass_next  = 1'b0;
            end
            rrds_pkg::ST_SET_E1:   state_next = rrds_pkg::ST_MUL_T;
            rrds_pkg::ST_MUL_T:    state_next = rrds_pkg::ST_DIV_LOAD;
            rrds_pkg::ST_DIV_LOAD:
            begin
                state_next = rrds_pkg::ST_DIV_STEP;
                cnt_next   = '0;
            end
            rrds_pkg::ST_DIV_STEP:
            begin
                if (cnt_reg == rrds_pkg::KDIV_LAST)
                    state_next = rrds_pkg::ST_ACC;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            rrds_pkg::ST_ACC:
            begin
                if (k_reg != rrds_pkg::TAYLOR_TERMS)
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = rrds_pkg::ST_MUL_T;
                end
                else if (!pass_reg)
                    state_next = rrds_pkg::ST_SET_F;
                else if (status.whole == '0)
                    state_next = rrds_pkg::ST_MUL_INF;
                else
                begin
                    state_next = rrds_pkg::ST_MUL_E;
                    cnt_next   = '0;
                end
            end
            rrds_pkg::ST_SET_F:
            begin
                state_next = rrds_pkg::ST_MUL_T;
                k_next     = 4'd1;
                pass_next  = 1'b1;
            end
            rrds_pkg::ST_MUL_E:    state_next = rrds_pkg::ST_TAKE_E;
            rrds_pkg::ST_TAKE_E:
            begin
                if (cnt_reg + 5'd1 == status.whole)
                    state_next = rrds_pkg::ST_MUL_INF;
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = rrds_pkg::ST_MUL_E;
                end
            end
            rrds_pkg::ST_MUL_INF:  state_next = rrds_pkg::ST_INF;
            rrds_pkg::ST_INF:      state_next = rrds_pkg::ST_MUL_IFW;
            rrds_pkg::ST_MUL_IFW:  state_next = rrds_pkg::ST_MUL_SRUN;
            rrds_pkg::ST_MUL_SRUN: state_next = rrds_pkg::ST_SRUN;
            rrds_pkg::ST_SRUN:     state_next = rrds_pkg::ST_MUL_RCW;
            rrds_pkg::ST_MUL_RCW:  state_next = rrds_pkg::ST_MUL_REC;
            rrds_pkg::ST_MUL_REC:  state_next = rrds_pkg::ST_REC;
            rrds_pkg::ST_REC:      state_next = rrds_pkg::ST_MUL_BAS;
            rrds_pkg::ST_MUL_BAS:  state_next = rrds_pkg::ST_SOIL;
            rrds_pkg::ST_SOIL:     state_next = rrds_pkg::ST_FINISH;
            rrds_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                    state_next = rrds_pkg::ST_IDLE;
            end
            default:               state_next = rrds_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.k     = k_reg;
        cmd.first = (cnt_reg == '0);
        case (state_reg)
            rrds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? rrds_pkg::OP_LOAD : rrds_pkg::OP_NONE;
            end
            rrds_pkg::ST_WDIV:     cmd.op = rrds_pkg::OP_WDIV;
            rrds_pkg::ST_MUL_X:    cmd.op = rrds_pkg::OP_MUL_X;
            rrds_pkg::ST_SET_E1:   cmd.op = rrds_pkg::OP_SET_E1;
            rrds_pkg::ST_MUL_T:    cmd.op = rrds_pkg::OP_MUL_T;
            rrds_pkg::ST_DIV_LOAD: cmd.op = rrds_pkg::OP_DIV_LOAD;
            rrds_pkg::ST_DIV_STEP: cmd.op = rrds_pkg::OP_DIV_STEP;
            rrds_pkg::ST_ACC:      cmd.op = rrds_pkg::OP_ACC;
            rrds_pkg::ST_SET_F:    cmd.op = rrds_pkg::OP_SET_F;
            rrds_pkg::ST_MUL_E:    cmd.op = rrds_pkg::OP_MUL_E;
            rrds_pkg::ST_TAKE_E:   cmd.op = rrds_pkg::OP_TAKE_E;
            rrds_pkg::ST_MUL_INF:  cmd.op = rrds_pkg::OP_MUL_INF;
            rrds_pkg::ST_INF:      cmd.op = rrds_pkg::OP_INF;
            rrds_pkg::ST_MUL_IFW:  cmd.op = rrds_pkg::OP_MUL_IFW;
            rrds_pkg::ST_MUL_SRUN: cmd.op = rrds_pkg::OP_MUL_SRUN;
            rrds_pkg::ST_SRUN:     cmd.op = rrds_pkg::OP_SRUN;
            rrds_pkg::ST_MUL_RCW:  cmd.op = rrds_pkg::OP_MUL_RCW;
            rrds_pkg::ST_MUL_REC:  cmd.op = rrds_pkg::OP_MUL_REC;
            rrds_pkg::ST_REC:      cmd.op = rrds_pkg::OP_REC;
            rrds_pkg::ST_MUL_BAS:  cmd.op = rrds_pkg::OP_MUL_BAS;
            rrds_pkg::ST_SOIL:     cmd.op = rrds_pkg::OP_SOIL;
            rrds_pkg::ST_FINISH:
                cmd.op = status.out_busy ? rrds_pkg::OP_NONE : rrds_pkg::OP_FINISH;
            default:               cmd.op = rrds_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== hdl/rrds_datapath.sv =====
// Datapath: configuration, stores, shared multiplier, dividers and output register.
module rrds_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rrds_pkg::cmd_t    cmd,
    output rrds_pkg::status_t status,
    input  rrds_pkg::in_t     in_data,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rrds_pkg::out_t    out_data
);

    // configuration
    logic [23:0] icap_reg, infc_reg, scap_reg;
    logic [15:0] shape_reg;
    logic [16:0] ifc_reg, rc_reg, bfc_reg;

    // stores and output
    logic [23:0] soil_reg;
    logic [31:0] ground_reg;
    logic        out_valid_reg, out_valid_next;
    rrds_pkg::out_t out_reg;

    // working registers
    logic [23:0] rain_reg, pet_reg, capd_reg, rem_reg;
    logic        m_lsb_reg;
    logic [16:0] w_reg;
    logic [65:0] prod_reg;
    logic [4:0]  whole_reg;
    logic [31:0] arg_reg, f_reg, term_reg, sum_reg, e1_reg;
    logic [31:0] dq_reg;
    logic [3:0]  drem_reg;
    logic [23:0] icept_reg, infil_reg, irun_reg, srun_reg, et_reg;
    logic [24:0] rec_reg, snew_reg;
    logic [31:0] bas_reg;

    // combinational helpers
    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [24:0] rem2;
    logic [31:0] dq_n;
    logic [3:0]  dr_n;
    logic [4:0]  r5;
    logic [23:0] m_val, icept_c, excess_c, infil_c;
    logic [35:0] inf_cap_c;
    logic [23:0] smf_c, et_c;
    logic [24:0] avail_c;
    logic [32:0] et_dem_full;
    logic [25:0] rec_tot_c;
    logic [23:0] s_fin_c;
    logic [33:0] gw_c, runoff_c;
    logic [16:0] ifc_c, rc_c, bfc_c;

    function automatic logic [16:0] frac_clamp(input logic [16:0] c);
        return (c > rrds_pkg::FRAC_ONE) ? rrds_pkg::FRAC_ONE : c;
    endfunction

    assign ifc_c = frac_clamp(ifc_reg);
    assign rc_c  = frac_clamp(rc_reg);
    assign bfc_c = frac_clamp(bfc_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            rrds_pkg::OP_MUL_X:
            begin
                mul_a = {18'd0, shape_reg};
                mul_b = {15'd0, w_reg};
            end
            rrds_pkg::OP_MUL_T:
            begin
                mul_a = {2'd0, term_reg};
                mul_b = arg_reg;
            end
            rrds_pkg::OP_MUL_E:
            begin
                mul_a = {2'd0, sum_reg};
                mul_b = e1_reg;
            end
            rrds_pkg::OP_MUL_INF:
            begin
                mul_a = {10'd0, infc_reg};
                mul_b = sum_reg;
            end
            rrds_pkg::OP_MUL_IFW:
            begin
                mul_a = {17'd0, ifc_c};
                mul_b = {15'd0, w_reg};
            end
            rrds_pkg::OP_MUL_SRUN:
            begin
                mul_a = prod_reg[33:0];
                mul_b = {8'd0, infil_reg};
            end
            rrds_pkg::OP_MUL_RCW:
            begin
                mul_a = {17'd0, rc_c};
                mul_b = {15'd0, w_reg};
            end
            rrds_pkg::OP_MUL_REC:
            begin
                mul_a = prod_reg[33:0];
                mul_b = {8'd0, infil_reg - srun_reg};
            end
            rrds_pkg::OP_MUL_BAS:
            begin
                mul_a = {17'd0, bfc_c};
                mul_b = ground_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one wetness quotient bit per cycle
    assign rem2 = {rem_reg, cmd.first ? m_lsb_reg : 1'b0};

    // eight quotient bits per cycle against the small Taylor divisor
    always_comb
    begin
        dq_n = dq_reg;
        dr_n = drem_reg;
        r5   = '0;
        for (int i = 0; i < 8; i++)
        begin
            r5   = {dr_n, dq_n[31]};
            dq_n = {dq_n[30:0], 1'b0};
            if (r5 >= {1'b0, cmd.k})
            begin
                dr_n    = 4'(r5 - {1'b0, cmd.k});
                dq_n[0] = 1'b1;
            end
            else
                dr_n = r5[3:0];
        end
    end

    always_comb
    begin
        m_val     = (soil_reg < scap_reg) ? soil_reg : scap_reg;
        icept_c   = (icap_reg < pet_reg) ? icap_reg : pet_reg;
        icept_c   = (icept_c < rain_reg) ? icept_c : rain_reg;
        excess_c  = rain_reg - icept_c;
        inf_cap_c = prod_reg[65:30];
        infil_c   = (inf_cap_c < {12'd0, excess_c}) ? inf_cap_c[23:0] : excess_c;

        smf_c       = infil_reg - srun_reg - rec_reg[23:0];
        avail_c     = {1'b0, soil_reg} + {1'b0, smf_c};
        et_dem_full = {16'd0, w_reg} * {17'd0, rrds_pkg::ET_SCALE};
        et_c        = ({7'd0, et_dem_full[32:16]} < (pet_reg - icept_reg))
                      ? {7'd0, et_dem_full[32:16]} : (pet_reg - icept_reg);

        // spill soil water above capacity into recharge
        if (snew_reg > {1'b0, scap_reg})
        begin
            rec_tot_c = {1'b0, rec_reg} + {1'b0, snew_reg - {1'b0, scap_reg}};
            s_fin_c   = scap_reg;
        end
        else
        begin
            rec_tot_c = {1'b0, rec_reg};
            s_fin_c   = snew_reg[23:0];
        end
        gw_c     = {2'd0, ground_reg} + {8'd0, rec_tot_c} - {2'd0, bas_reg};
        runoff_c = {10'd0, irun_reg} + {10'd0, srun_reg} + {2'd0, bas_reg};
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rrds_pkg::OP_LOAD:
            begin
                rain_reg  <= in_data.rainfall;
                pet_reg   <= in_data.pet;
                capd_reg  <= (scap_reg == '0) ? 24'd1 : scap_reg;
                rem_reg   <= {1'b0, m_val[23:1]};
                m_lsb_reg <= m_val[0];
                w_reg     <= '0;
            end
            rrds_pkg::OP_WDIV:
            begin
                if (rem2 >= {1'b0, capd_reg})
                begin
                    rem_reg <= 24'(rem2 - {1'b0, capd_reg});
                    w_reg   <= {w_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[23:0];
                    w_reg   <= {w_reg[15:0], 1'b0};
                end
            end
            rrds_pkg::OP_SET_E1:
            begin
                whole_reg <= prod_reg[32] ? rrds_pkg::WHOLE_MAX : {1'b0, prod_reg[31:28]};
                f_reg     <= {2'd0, prod_reg[27:0], 2'd0};
                arg_reg   <= rrds_pkg::ONE30;
                sum_reg   <= rrds_pkg::ONE30;
                term_reg  <= rrds_pkg::ONE30;
            end
            rrds_pkg::OP_SET_F:
            begin
                e1_reg   <= sum_reg;
                arg_reg  <= f_reg;
                sum_reg  <= rrds_pkg::ONE30;
                term_reg <= rrds_pkg::ONE30;
            end
            rrds_pkg::OP_DIV_LOAD:
            begin
                dq_reg   <= {1'b0, prod_reg[60:30]};
                drem_reg <= '0;
            end
            rrds_pkg::OP_DIV_STEP:
            begin
                dq_reg   <= dq_n;
                drem_reg <= dr_n;
            end
            rrds_pkg::OP_ACC:
            begin
                term_reg <= dq_reg;
                if (cmd.k[0])
                    sum_reg <= (sum_reg >= dq_reg) ? sum_reg - dq_reg : '0;
                else
                    sum_reg <= sum_reg + dq_reg;
            end
            rrds_pkg::OP_TAKE_E: sum_reg <= prod_reg[61:30];
            rrds_pkg::OP_INF:
            begin
                icept_reg <= icept_c;
                infil_reg <= infil_c;
                irun_reg  <= excess_c - infil_c;
            end
            rrds_pkg::OP_SRUN:   srun_reg <= prod_reg[55:32];
            rrds_pkg::OP_REC:    rec_reg  <= {1'b0, prod_reg[55:32]};
            rrds_pkg::OP_SOIL:
            begin
                bas_reg  <= prod_reg[47:16];
                et_reg   <= et_c;
                snew_reg <= (avail_c > {1'b0, et_c}) ? avail_c - {1'b0, et_c} : '0;
            end
            rrds_pkg::OP_FINISH:
            begin
                out_reg.runoff       <= (runoff_c > {10'd0, rrds_pkg::MAX24})
                                        ? rrds_pkg::MAX24 : runoff_c[23:0];
                out_reg.soil_et      <= et_reg;
                out_reg.soil_level   <= s_fin_c;
                out_reg.ground_level <= (gw_c[33:32] != 2'd0) ? rrds_pkg::MAX32 : gw_c[31:0];
            end
            default:
            begin
            end
        endcase
        case (cmd.op)
            rrds_pkg::OP_MUL_X, rrds_pkg::OP_MUL_T, rrds_pkg::OP_MUL_E,
            rrds_pkg::OP_MUL_INF, rrds_pkg::OP_MUL_IFW, rrds_pkg::OP_MUL_SRUN,
            rrds_pkg::OP_MUL_RCW, rrds_pkg::OP_MUL_REC, rrds_pkg::OP_MUL_BAS:
                prod_reg <= mul_a * mul_b;
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = (cmd.op == rrds_pkg::OP_FINISH) | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icap_reg      <= rrds_pkg::INTERCEPT_CAPACITY_RESET;
            infc_reg      <= rrds_pkg::INFILTRATION_COEFF_RESET;
            shape_reg     <= rrds_pkg::INFILTRATION_SHAPE_RESET;
            scap_reg      <= rrds_pkg::SOIL_CAPACITY_RESET;
            ifc_reg       <= rrds_pkg::INTERFLOW_COEFF_RESET;
            rc_reg        <= rrds_pkg::RECHARGE_COEFF_RESET;
            bfc_reg       <= rrds_pkg::BASEFLOW_COEFF_RESET;
            soil_reg      <= rrds_pkg::SOIL_STORE_RESET;
            ground_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.op == rrds_pkg::OP_FINISH)
            begin
                soil_reg   <= s_fin_c;
                ground_reg <= (gw_c[33:32] != 2'd0) ? rrds_pkg::MAX32 : gw_c[31:0];
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    rrds_pkg::REG_INTERCEPT_CAPACITY: icap_reg  <= cfg_data;
                    rrds_pkg::REG_INFILTRATION_COEFF: infc_reg  <= cfg_data;
                    rrds_pkg::REG_INFILTRATION_SHAPE: shape_reg <= cfg_data[15:0];
                    rrds_pkg::REG_SOIL_CAPACITY:      scap_reg  <= cfg_data;
                    rrds_pkg::REG_INTERFLOW_COEFF:    ifc_reg   <= cfg_data[16:0];
                    rrds_pkg::REG_RECHARGE_COEFF:     rc_reg    <= cfg_data[16:0];
                    rrds_pkg::REG_BASEFLOW_COEFF:     bfc_reg   <= cfg_data[16:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign status.whole    = whole_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

// ===== hdl/rainfall_runoff_daily_step.sv =====
// Top level of the daily rainfall-runoff step: sequencer plus datapath.
// One day runs bit-serial division for soil wetness, two 13-term exp Taylor series
// through one shared multiplier and an 8-bit-per-cycle small divider, setup steps,
// one multiply per whole unit of the exponent (0 to 16 units), and water balance and
// output. The next day is accepted in the idle state that follows the result's write;
// a finished result waits in the output register without holding up the next day's
// work until its final write. Write configuration only while no day is in flight; it
// applies to later days.
module rainfall_runoff_daily_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rrds_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rrds_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_data
);

    rrds_pkg::cmd_t    cmd;
    rrds_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rrds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rrds_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== test/rainfall_runoff_daily_step_checker.sv =====
// Checker for the daily rainfall-runoff step: predicts each day and compares results.
module rainfall_runoff_daily_step_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  rrds_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  rrds_pkg::out_t out_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_data,
    output int             errors,
    output int             pending,
    output int             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] Q30 = 64'd1 << 30;

    logic [23:0] icept_cap, infil_coeff, soil_cap;
    logic [15:0] infil_shape;
    logic [16:0] ifw_coeff, rch_coeff, bas_coeff;
    logic [23:0] soil_now;
    logic [31:0] ground_now;

    rrds_pkg::out_t expected_days[$];

    function automatic logic [63:0] frac_limit(input logic [16:0] c);
        return (c > rrds_pkg::FRAC_ONE) ? 64'(rrds_pkg::FRAC_ONE) : 64'(c);
    endfunction

    // exp(-f) for 0 <= f <= 1.0, all in Q.30
    function automatic logic [63:0] decay_unit(input logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] term;
        acc = Q30;
        term = Q30;
        for (int k = 1; k <= 13; k++)
        begin
            term = ((term * f) >> 30) / k;
            if (k % 2 == 1)
                acc = (acc >= term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic [63:0] decay(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] e1;
        logic [63:0] whole;
        whole = x >> 30;
        r = decay_unit(x & (Q30 - 1));
        e1 = decay_unit(Q30);
        for (int i = 0; i < 16; i++)
        begin
            if (i < whole)
                r = (r * e1) >> 30;
        end
        return r;
    endfunction

    // Advance the stores by one day and return the day's word.
    task automatic run_day(input rrds_pkg::in_t day, output rrds_pkg::out_t res);
        logic [63:0] cap, capd, w, x, inf_cap, icept, excess, infil, irun;
        logic [63:0] srun, rec, smf, pot, et, avail, s_new, bas, gw, runoff;
        cap = 64'(soil_cap);
        capd = (cap == 0) ? 64'd1 : cap;
        w = (((64'(soil_now) < cap) ? 64'(soil_now) : cap) << 16) / capd;
        x = (64'(infil_shape) * w) << 2;
        inf_cap = (64'(infil_coeff) * decay(x)) >> 30;
        icept = 64'(icept_cap);
        if (64'(day.pet) < icept) icept = 64'(day.pet);
        if (64'(day.rainfall) < icept) icept = 64'(day.rainfall);
        excess = 64'(day.rainfall) - icept;
        infil = (inf_cap < excess) ? inf_cap : excess;
        irun = excess - infil;
        srun = (frac_limit(ifw_coeff) * w * infil) >> 32;
        rec = (frac_limit(rch_coeff) * w * (infil - srun)) >> 32;
        smf = infil - srun - rec;
        pot = 64'(day.pet) - icept;
        et = (64'(rrds_pkg::ET_SCALE) * w) >> 16;
        if (pot < et) et = pot;
        avail = 64'(soil_now) + smf;
        s_new = (avail > et) ? avail - et : 64'd0;
        if (s_new > cap)
        begin
            rec = rec + s_new - cap;
            s_new = cap;
        end
        bas = (frac_limit(bas_coeff) * 64'(ground_now)) >> 16;
        gw = 64'(ground_now) + rec - bas;
        if (gw > 64'(rrds_pkg::MAX32)) gw = 64'(rrds_pkg::MAX32);
        runoff = irun + srun + bas;
        if (runoff > 64'(rrds_pkg::MAX24)) runoff = 64'(rrds_pkg::MAX24);
        soil_now = s_new[23:0];
        ground_now = gw[31:0];
        res.runoff = runoff[23:0];
        res.soil_et = et[23:0];
        res.soil_level = soil_now;
        res.ground_level = ground_now;
    endtask

    task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("MISMATCH day %0d %s: expected %0d got %0d", checked, field, exp_v, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rrds_pkg::out_t want;
        rrds_pkg::out_t pred;
        if (!rst_n)
        begin
            icept_cap = rrds_pkg::INTERCEPT_CAPACITY_RESET;
            infil_coeff = rrds_pkg::INFILTRATION_COEFF_RESET;
            infil_shape = rrds_pkg::INFILTRATION_SHAPE_RESET;
            soil_cap = rrds_pkg::SOIL_CAPACITY_RESET;
            ifw_coeff = rrds_pkg::INTERFLOW_COEFF_RESET;
            rch_coeff = rrds_pkg::RECHARGE_COEFF_RESET;
            bas_coeff = rrds_pkg::BASEFLOW_COEFF_RESET;
            soil_now = rrds_pkg::SOIL_STORE_RESET;
            ground_now = '0;
            expected_days.delete();
            errors = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rrds_pkg::REG_INTERCEPT_CAPACITY: icept_cap = cfg_data;
                    rrds_pkg::REG_INFILTRATION_COEFF: infil_coeff = cfg_data;
                    rrds_pkg::REG_INFILTRATION_SHAPE: infil_shape = cfg_data[15:0];
                    rrds_pkg::REG_SOIL_CAPACITY:      soil_cap = cfg_data;
                    rrds_pkg::REG_INTERFLOW_COEFF:    ifw_coeff = cfg_data[16:0];
                    rrds_pkg::REG_RECHARGE_COEFF:     rch_coeff = cfg_data[16:0];
                    rrds_pkg::REG_BASEFLOW_COEFF:     bas_coeff = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_days.size() == 0)
                begin
                    report("unexpected word", 0, 1);
                end
                else
                begin
                    want = expected_days.pop_front();
                    if (want.runoff !== out_data.runoff)
                        report("runoff", want.runoff, out_data.runoff);
                    if (want.soil_et !== out_data.soil_et)
                        report("soil_et", want.soil_et, out_data.soil_et);
                    if (want.soil_level !== out_data.soil_level)
                        report("soil_level", want.soil_level, out_data.soil_level);
                    if (want.ground_level !== out_data.ground_level)
                        report("ground_level", want.ground_level, out_data.ground_level);
                end
                checked++;
            end
            if (in_valid && in_ready)
            begin
                run_day(in_data, pred);
                expected_days.push_back(pred);
            end
            pending = expected_days.size();
        end
    end

endmodule

// ===== test/rainfall_runoff_daily_step_tb.sv =====
// Testbench top for the daily rainfall-runoff step: stimulus, idling and verdict.
module rainfall_runoff_daily_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int MM = 4096;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    rrds_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    rrds_pkg::out_t out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [2:0]     cfg_index;
    logic [23:0]    cfg_data;

    int errors;
    int pending;
    int checked;
    int sender_idle;
    int receiver_idle;
    int days_sent;
    int settings_used;

    rainfall_runoff_daily_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rainfall_runoff_daily_step_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("Timeout with %0d days outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_idle);

    task automatic send_day(input logic [23:0] rain, input logic [23:0] pet);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{rainfall: rain, pet: pet};
        do @(posedge clk); while (!in_ready);
        days_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid after the last accepted word, then wait for every result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_settings(input logic [23:0] ic, input logic [23:0] ifc,
                                 input logic [15:0] sh, input logic [23:0] cap,
                                 input logic [16:0] ifw, input logic [16:0] rc,
                                 input logic [16:0] bf);
        drain();
        write_reg(rrds_pkg::REG_INTERCEPT_CAPACITY, ic);
        write_reg(rrds_pkg::REG_INFILTRATION_COEFF, ifc);
        write_reg(rrds_pkg::REG_INFILTRATION_SHAPE, {8'd0, sh});
        write_reg(rrds_pkg::REG_SOIL_CAPACITY, cap);
        write_reg(rrds_pkg::REG_INTERFLOW_COEFF, {7'd0, ifw});
        write_reg(rrds_pkg::REG_RECHARGE_COEFF, {7'd0, rc});
        write_reg(rrds_pkg::REG_BASEFLOW_COEFF, {7'd0, bf});
        settings_used++;
    endtask

    function automatic logic [16:0] pick_frac();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return rrds_pkg::FRAC_ONE;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_settings();
        load_settings($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 8 * MM)),
                      $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 400 * MM)),
                      16'($urandom),
                      $urandom_range(0, 3) == 0 ? 24'($urandom_range(4096, 24'hFFFFFF))
                                                : 24'($urandom_range(4096, 600 * MM)),
                      pick_frac(), pick_frac(), pick_frac());
    endtask

    task automatic random_day();
        logic [23:0] rain;
        logic [23:0] pet;
        case ($urandom_range(0, 9))
            0:
            begin
                rain = 24'($urandom);
                pet = 24'($urandom);
            end
            1, 2, 3:
            begin
                rain = '0;
                pet = 24'($urandom_range(0, 12 * MM));
            end
            default:
            begin
                rain = 24'($urandom_range(0, 80 * MM));
                pet = 24'($urandom_range(0, 12 * MM));
            end
        endcase
        send_day(rain, pet);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        sender_idle = 0;
        receiver_idle = 0;
        days_sent = 0;
        settings_used = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes at reset settings
        send_day(24'd0, 24'd0);
        send_day(rrds_pkg::MAX24, rrds_pkg::MAX24);
        send_day(rrds_pkg::MAX24, 24'd0);
        send_day(24'd0, rrds_pkg::MAX24);
        send_day(24'd3000, 24'd100);
        send_day(24'h555555, 24'hAAAAAA);
        send_day(24'hAAAAAA, 24'h555555);
        // soil underflow: dry days with heavy evaporation
        repeat (3) send_day(24'd0, 24'(40 * MM));
        // every register at its maximum, fractions above one, unknown index ignored
        load_settings(rrds_pkg::MAX24, rrds_pkg::MAX24, 16'hFFFF, rrds_pkg::MAX24,
                      17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        write_reg(REG_UNUSED, rrds_pkg::MAX24);
        send_day(rrds_pkg::MAX24, 24'd0);
        send_day(rrds_pkg::MAX24, rrds_pkg::MAX24);
        // shrink capacity under a full store: store above capacity and overflow
        load_settings(24'd0, rrds_pkg::MAX24, 16'd0, 24'd4096, 17'd0, 17'd0, 17'd0);
        send_day(rrds_pkg::MAX24, 24'd0);
        send_day(24'd100, 24'd50);
        // zero capacity sends all soil water to recharge
        load_settings(24'd0, rrds_pkg::MAX24, 16'd0, 24'd0, rrds_pkg::FRAC_ONE,
                      rrds_pkg::FRAC_ONE, rrds_pkg::FRAC_ONE);
        send_day(24'(50 * MM), 24'(2 * MM));
        send_day(rrds_pkg::MAX24, 24'd1);
        load_settings(rrds_pkg::INTERCEPT_CAPACITY_RESET, rrds_pkg::INFILTRATION_COEFF_RESET,
                      rrds_pkg::INFILTRATION_SHAPE_RESET, rrds_pkg::SOIL_CAPACITY_RESET,
                      rrds_pkg::INTERFLOW_COEFF_RESET, rrds_pkg::RECHARGE_COEFF_RESET,
                      rrds_pkg::BASEFLOW_COEFF_RESET);
        repeat (4) send_day(24'(20 * MM), 24'(5 * MM));

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle = (phase == 0) ? 34 : (phase == 1) ? 49 : 0;
            receiver_idle = (phase == 0) ? 49 : (phase == 1) ? 34 : 0;
            random_settings();
            for (int n = 0; n < 200; n++)
            begin
                // hold the sender until every day so far has come back
                if (n == 100)
                begin
                    drain();
                    random_settings();
                end
                random_day();
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        drain();
        repeat (300) @(posedge clk);
        $display("Sent %0d days under %0d register settings, %0d results checked",
                 days_sent, settings_used, checked);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
